// ----- hw/rtl/pcp_pkg.sv -----
// Shared types, command codes and seed table for the permutation-conjugation generator.
`timescale 1ns / 1ps

package pcp_pkg;

    localparam int SLOTS      = 32;
    localparam int IDX_W      = 5;
    localparam int VAL_W      = 8;
    localparam int WORD_W     = 32;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = 3;
    localparam int CNT_W      = 4;

    localparam logic [1:0] CMD_LOAD_BASE = 2'd0;
    localparam logic [1:0] CMD_LOAD_RUN  = 2'd1;
    localparam logic [1:0] CMD_LOAD_MIX  = 2'd2;
    localparam logic [1:0] CMD_STEP      = 2'd3;

    typedef logic [VAL_W-1:0] byte_t;
    typedef logic [IDX_W-1:0] perm_t;

    typedef struct packed {
        logic [1:0]  command;
        perm_t       entry_index;
        byte_t       entry_value;
    } req_t;

    // Pipeline occupancy reported by the core
    typedef struct packed {
        logic stage_step;
        logic done_step;
    } core_status_t;

    localparam byte_t SEED [SLOTS] = '{
        8'd1,   8'd2,   8'd3,   8'd5,   8'd7,   8'd11,  8'd13,  8'd17,
        8'd19,  8'd23,  8'd29,  8'd31,  8'd33,  8'd37,  8'd39,  8'd41,
        8'd143, 8'd151, 8'd157, 8'd159, 8'd161, 8'd167, 8'd171, 8'd175,
        8'd212, 8'd85,  8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
    };

endpackage

// ----- hw/rtl/pcp_req_if.sv -----
// Request channel: command with entry index and value.
`timescale 1ns / 1ps

interface pcp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [4:0] entry_index;
    logic [7:0] entry_value;

    modport source (output valid, command, entry_index, entry_value, input ready);
    modport sink (input valid, command, entry_index, entry_value, output ready);
endinterface

// ----- hw/rtl/pcp_rsp_if.sv -----
// Result channel: one random word per step request.
`timescale 1ns / 1ps

interface pcp_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, random_word, input ready);
    modport sink (input valid, random_word, output ready);
endinterface

// ----- hw/rtl/pcp_core.sv -----
// Request register and permutation/mix state with the parallel step update.
`timescale 1ns / 1ps

module pcp_core
    import pcp_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  req_t         req_in,
    output byte_t        mix [ENTRIES],
    output core_status_t status
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W:0] LIMIT = (IDX_W + 1)'(ENTRIES);

    req_t  req_reg;
    logic  valid_reg;
    logic  done_reg;
    byte_t mix_reg  [ENTRIES];
    perm_t base_reg [ENTRIES];
    perm_t inv_reg  [ENTRIES];
    perm_t run_reg  [ENTRIES];
    byte_t mix_next [ENTRIES];
    perm_t run_next [ENTRIES];

    logic  idx_ok;
    logic  val_ok;
    perm_t val_p;
    logic  do_step;

    // Register the accepted request's valid flag and the step-done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= take;
            done_reg  <= do_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req_in;
        end
    end

    assign val_p   = req_reg.entry_value[IDX_W-1:0];
    assign idx_ok  = {1'b0, req_reg.entry_index} < LIMIT;
    assign val_ok  = {1'b0, val_p} < LIMIT;
    assign do_step = valid_reg && (req_reg.command == CMD_STEP);

    // Step: XOR each mix byte with the one it points to, conjugate the running permutation
    always_comb
    begin
        perm_t a;
        perm_t b;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if ({1'b0, run_reg[i]} < LIMIT)
            begin
                mix_next[i] = mix_reg[i] ^ mix_reg[run_reg[i][IW-1:0]];
            end
            else
            begin
                mix_next[i] = mix_reg[i];
            end
            a = inv_reg[i];
            b = ({1'b0, a} < LIMIT) ? run_reg[a[IW-1:0]] : '0;
            run_next[i] = ({1'b0, b} < LIMIT) ? base_reg[b[IW-1:0]] : '0;
        end
    end

    // Update the mix bytes from a step or a byte load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                mix_reg[i] <= SEED[i];
            end
        end
        else if (do_step)
        begin
            mix_reg <= mix_next;
        end
        else if (valid_reg && idx_ok && (req_reg.command == CMD_LOAD_MIX))
        begin
            mix_reg[req_reg.entry_index[IW-1:0]] <= req_reg.entry_value;
        end
    end

    // Update the permutations; loading the base also fills its inverse
    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            run_reg <= run_next;
        end
        else if (valid_reg && idx_ok)
        begin
            unique case (req_reg.command)
                CMD_LOAD_BASE:
                begin
                    base_reg[req_reg.entry_index[IW-1:0]] <= val_p;
                    if (val_ok)
                    begin
                        inv_reg[val_p[IW-1:0]] <= req_reg.entry_index;
                    end
                end
                CMD_LOAD_RUN:
                begin
                    run_reg[req_reg.entry_index[IW-1:0]] <= val_p;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign mix               = mix_reg;
    assign status.stage_step = valid_reg && (req_reg.command == CMD_STEP);
    assign status.done_step  = done_reg;

endmodule

// ----- hw/rtl/pcp_sum.sv -----
// Two-level adder tree that folds the updated mix bytes into one word.
`timescale 1ns / 1ps

module pcp_sum
    import pcp_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  byte_t             mix [ENTRIES],
    output logic              busy,
    output logic              word_valid,
    output logic [WORD_W-1:0] word
);

    localparam int GROUP  = 4;
    localparam int GROUPS = (ENTRIES + GROUP - 1) / GROUP;

    logic [WORD_W-1:0] part_reg  [GROUPS];
    logic [WORD_W-1:0] part_next [GROUPS];
    logic              part_valid_reg;

    // Sum each group of shifted bytes
    always_comb
    begin
        logic [WORD_W-1:0] acc;
        for (int g = 0; g < GROUPS; g++)
        begin
            acc = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < ENTRIES)
                begin
                    acc = acc + (WORD_W'(mix[g * GROUP + k]) << (g * GROUP + k));
                end
            end
            part_next[g] = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_valid_reg <= 1'b0;
        end
        else
        begin
            part_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            part_reg <= part_next;
        end
    end

    // Fold the group sums
    always_comb
    begin
        logic [WORD_W-1:0] tot;
        tot = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            tot = tot + part_reg[g];
        end
        word = tot;
    end

    assign word_valid = part_valid_reg;
    assign busy       = part_valid_reg;

endmodule

// ----- hw/rtl/pcp_fifo.sv -----
// Small result queue that drives the result channel.
`timescale 1ns / 1ps

module pcp_fifo
    import pcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [WORD_W-1:0] push_data,
    output logic [CNT_W-1:0]  count,
    pcp_rsp_if.source         rsp
);

    logic [WORD_W-1:0] slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              pop;

    assign pop = rsp.valid && rsp.ready;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign rsp.valid       = count_reg != '0;
    assign rsp.random_word = slot_reg[rd_ptr_reg];
    assign count           = count_reg;

endmodule

// ----- hw/rtl/permutation_conjugation_prng.sv -----
// Top level of the permutation-conjugation pseudo-random generator.
//
//   channel | dir | payload                                | per request
//   --------+-----+----------------------------------------+-----------------------
//   req     | in  | command, entry_index, entry_value      | load or step
//   rsp     | out | random_word                            | one per step request
//
// One request is taken every cycle while req.ready is high; a step result passes
// through the request register, the state update, the adder tree's group-sum
// register and the result queue before it reaches rsp. Reset clears the pipeline
// and queue and loads the mix bytes from the seed table; permutations hold nothing
// until loaded. An eight-entry result queue keeps taking requests while results
// wait; req.ready drops only when queued plus in-flight steps would fill it.
`timescale 1ns / 1ps

module permutation_conjugation_prng
    import pcp_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    pcp_req_if.sink   req,
    pcp_rsp_if.source rsp
);

    req_t              req_word;
    logic              take;
    byte_t             mix [ENTRIES];
    core_status_t      status;
    logic              sum_busy;
    logic              word_valid;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  count;
    logic [CNT_W:0]    credit_used;

    assign req_word.command     = req.command;
    assign req_word.entry_index = req.entry_index;
    assign req_word.entry_value = req.entry_value;
    assign take                 = req.valid && req.ready;

    // Accept only when every step in flight has a queue slot
    assign credit_used = (CNT_W + 1)'(count)
                       + (CNT_W + 1)'(status.stage_step)
                       + (CNT_W + 1)'(status.done_step)
                       + (CNT_W + 1)'(sum_busy);
    assign req.ready   = credit_used < (CNT_W + 1)'(FIFO_DEPTH);

    pcp_core #(
        .ENTRIES (ENTRIES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .req_in (req_word),
        .mix    (mix),
        .status (status)
    );

    pcp_sum #(
        .ENTRIES (ENTRIES)
    ) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (status.done_step),
        .mix        (mix),
        .busy       (sum_busy),
        .word_valid (word_valid),
        .word       (word)
    );

    pcp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (word_valid),
        .push_data (word),
        .count     (count),
        .rsp       (rsp)
    );

endmodule
